[src/zlc_pkg.sv]
package zlc_pkg;

   localparam int COORD_W          = 20;
   localparam int ID_W             = 10;
   localparam int CIDX_W           = 12;
   localparam int ZONE_SLOTS_DEF   = 512;
   localparam int REGION_SLOTS_DEF = 16;
   localparam int PLAYER_SLOTS_DEF = 64;

   typedef enum logic [2:0] {
      CMD_LOCATE       = 3'd0,
      CMD_WR_REGION    = 3'd1,
      CMD_WR_ZONE      = 3'd2,
      CMD_PARTITION    = 3'd3,
      CMD_RESET_PLAYER = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SHOW   = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_HIDE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_ZONE_COUNT     = 2'd0,
      CSR_REGION_COUNT   = 2'd1,
      CSR_QUADRANT_BASE  = 2'd2,
      CSR_INVALID_REGION = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PLAYER,
      ST_CZ,
      ST_R_RD,
      ST_R_CHK,
      ST_Z_RD,
      ST_Z_CHK,
      ST_FIN,
      ST_P_RD,
      ST_P_CHK,
      ST_OUT
   } state_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type min_x;
      coord_type min_y;
      coord_type min_z;
      coord_type max_x;
      coord_type max_y;
      coord_type max_z;
   } box_type;

   typedef struct packed {
      box_type         box;
      logic [ID_W-1:0] id;
   } store_entry_type;

   typedef struct packed {
      logic              ok;
      logic [CIDX_W-1:0] idx;
      logic [ID_W-1:0]   zid;
      logic [ID_W-1:0]   region;
   } player_entry_type;

   typedef struct packed {
      logic wr_en;
      logic shown_wr_en;
      logic shown_val;
      logic clear_all;
   } pl_ctrl_type;

   typedef struct packed {
      logic [2:0]      command;
      logic [5:0]      player;
      logic            is_spawned;
      logic            show_pref;
      coord_type       pos_x;
      coord_type       pos_y;
      coord_type       pos_z;
      coord_type       box_max_x;
      coord_type       box_max_y;
      coord_type       box_max_z;
      logic [8:0]      entry_index;
      logic [ID_W-1:0] entry_id;
   } req_type;

   typedef struct packed {
      logic [1:0]      action;
      logic            zone_found;
      logic [ID_W-1:0] zone_id;
      logic [ID_W-1:0] region_id;
      logic            partition_error;
   } rsp_type;

   // point inside box on all three axes, bounds inclusive
   function automatic logic box_holds(box_type b, coord_type x, coord_type y, coord_type z);
      box_holds = (b.min_x <= x) && (x <= b.max_x) &&
                  (b.min_y <= y) && (y <= b.max_y) &&
                  (b.min_z <= z) && (z <= b.max_z);
   endfunction

   // zone x/y extent lies within region box
   function automatic logic fits_xy(box_type zb, box_type rb);
      fits_xy = !((zb.min_x < rb.min_x) || (rb.max_x < zb.max_x) ||
                  (zb.min_y < rb.min_y) || (rb.max_y < zb.max_y));
   endfunction

endpackage

[src/zlc_zone_mem.sv]
module zlc_zone_mem
   import zlc_pkg::*;
#(
   parameter int ZONE_SLOTS = ZONE_SLOTS_DEF,
   localparam int ZW = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [ZW-1:0]   wr_addr,
   input  store_entry_type wr_entry,
   input  logic [ZW-1:0]   rd_addr,
   output store_entry_type rd_entry_ff
);

   store_entry_type mem [ZONE_SLOTS];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

endmodule

[src/zlc_region_mem.sv]
module zlc_region_mem
   import zlc_pkg::*;
#(
   parameter int REGION_SLOTS = REGION_SLOTS_DEF,
   parameter int ZONE_SLOTS   = ZONE_SLOTS_DEF,
   localparam int RW  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1,
   localparam int ZCW = $clog2(ZONE_SLOTS + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  logic [RW-1:0]   wr_addr,
   input  store_entry_type wr_entry,
   input  logic            from_wr_en,
   input  logic [RW-1:0]   from_wr_addr,
   input  logic [ZCW-1:0]  from_wr_val,
   input  logic            to_wr_en,
   input  logic [RW-1:0]   to_wr_addr,
   input  logic [ZCW-1:0]  to_wr_val,
   input  logic [RW-1:0]   rd_addr,
   output store_entry_type rd_entry_ff,
   output logic [ZCW-1:0]  rd_from,
   output logic [ZCW-1:0]  rd_to
);

   store_entry_type   mem      [REGION_SLOTS];
   logic [ZCW-1:0]    from_mem [REGION_SLOTS];
   logic [ZCW-1:0]    to_mem   [REGION_SLOTS];
   logic [REGION_SLOTS-1:0] from_vld_ff;
   logic [REGION_SLOTS-1:0] to_vld_ff;
   logic [ZCW-1:0]    from_q_ff;
   logic [ZCW-1:0]    to_q_ff;
   logic              from_v_ff;
   logic              to_v_ff;

   // box and id store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   // run bounds store
   always_ff @(posedge clock) begin
      if (from_wr_en) begin
         from_mem[from_wr_addr] <= from_wr_val;
      end
      if (to_wr_en) begin
         to_mem[to_wr_addr] <= to_wr_val;
      end
      from_q_ff <= from_mem[rd_addr];
      to_q_ff   <= to_mem[rd_addr];
   end

   // bound valid bits, unwritten bounds read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         from_vld_ff <= '0;
         to_vld_ff   <= '0;
         from_v_ff   <= 1'b0;
         to_v_ff     <= 1'b0;
      end else begin
         if (from_wr_en) begin
            from_vld_ff[from_wr_addr] <= 1'b1;
         end
         if (to_wr_en) begin
            to_vld_ff[to_wr_addr] <= 1'b1;
         end
         from_v_ff <= from_vld_ff[rd_addr];
         to_v_ff   <= to_vld_ff[rd_addr];
      end
   end

   assign rd_from = from_v_ff ? from_q_ff : '0;
   assign rd_to   = to_v_ff ? to_q_ff : '0;

endmodule

[src/zlc_player_mem.sv]
module zlc_player_mem
   import zlc_pkg::*;
#(
   parameter int PLAYER_SLOTS = PLAYER_SLOTS_DEF,
   localparam int PW = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [PW-1:0]    addr,
   input  pl_ctrl_type      ctrl,
   input  player_entry_type wr_entry,
   input  logic [ID_W-1:0]  clr_region,
   output player_entry_type rd_entry,
   output logic             rd_shown
);

   player_entry_type        mem [PLAYER_SLOTS];
   player_entry_type        rd_q_ff;
   logic [PLAYER_SLOTS-1:0] live_ff;
   logic [PLAYER_SLOTS-1:0] shown_ff;
   logic                    live_q_ff;
   logic                    shown_q_ff;
   logic [ID_W-1:0]         clr_reg_ff;

   // cache entries
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[addr] <= wr_entry;
      end
      rd_q_ff <= mem[addr];
   end

   // live and shown bits; a dead entry reads as cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff    <= '0;
         shown_ff   <= '0;
         live_q_ff  <= 1'b0;
         shown_q_ff <= 1'b0;
         clr_reg_ff <= '0;
      end else begin
         if (ctrl.clear_all) begin
            live_ff    <= '0;
            clr_reg_ff <= clr_region;
         end else if (ctrl.wr_en) begin
            live_ff[addr] <= 1'b1;
         end
         if (ctrl.shown_wr_en) begin
            shown_ff[addr] <= ctrl.shown_val;
         end
         live_q_ff  <= live_ff[addr];
         shown_q_ff <= shown_ff[addr];
      end
   end

   always_comb begin
      if (live_q_ff) begin
         rd_entry = rd_q_ff;
      end else begin
         rd_entry        = '0;
         rd_entry.region = clr_reg_ff;
      end
   end

   assign rd_shown = shown_q_ff;

endmodule

[src/two_level_box_zone_locator_top.sv]
// Writes, player reset and unknown commands pass through the execute state to the output state.
// Locate: a cached-zone hit needs only the cached zone check; on a miss the regions are tested,
// then the zones in the matching run, one memory read per step.
// Partition: walks the zone memory one zone per step, closing a run at each region change.
// One item at a time; the next beat is accepted once the result is registered.
// Reset: synchronous, clears control, config, player caches and shown flags.
module two_level_box_zone_locator_top
   import zlc_pkg::*;
#(
   parameter int ZONE_SLOTS   = ZONE_SLOTS_DEF,
   parameter int REGION_SLOTS = REGION_SLOTS_DEF,
   parameter int PLAYER_SLOTS = PLAYER_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wr_data
);

   localparam int ZW  = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
   localparam int ZCW = $clog2(ZONE_SLOTS + 1);
   localparam int RW  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int RCW = $clog2(REGION_SLOTS + 1);
   localparam int PW  = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;

   // config registers
   logic [9:0]      zone_count_ff;
   logic [4:0]      region_count_ff;
   logic [ID_W-1:0] qbase_ff;
   logic [ID_W-1:0] inv_ff;

   // sequencer state and work registers
   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic [RCW-1:0]   r_ff, r_in;
   logic [ZCW-1:0]   z_ff, z_in;
   logic [ZCW-1:0]   hi_ff, hi_in;
   logic             ok_ff, ok_in;
   logic [CIDX_W-1:0] zidx_ff, zidx_in;
   logic [ID_W-1:0]  zid_ff, zid_in;
   logic [ID_W-1:0]  reg_ff, reg_in;
   action_type       act_ff, act_in;
   logic             err_ff, err_in;
   player_entry_type prev_ff, prev_in;
   logic             shown_ff, shown_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // memory ports
   logic             zm_wr_en;
   logic [ZW-1:0]    zm_wr_addr;
   logic [ZW-1:0]    zm_rd_addr;
   store_entry_type  zm_rd_entry;
   logic             rm_wr_en;
   logic [RW-1:0]    rm_wr_addr;
   logic [RW-1:0]    rm_rd_addr;
   store_entry_type  rm_rd_entry;
   logic [ZCW-1:0]   rm_rd_from;
   logic [ZCW-1:0]   rm_rd_to;
   logic             from_wr_en;
   logic [RW-1:0]    from_wr_addr;
   logic [ZCW-1:0]   from_wr_val;
   logic             to_wr_en;
   logic [ZCW-1:0]   to_wr_val;
   store_entry_type  item_entry;
   pl_ctrl_type      pl_ctrl;
   player_entry_type pl_wr_entry;
   player_entry_type pl_rd_entry;
   logic             pl_rd_shown;

   // decoded conditions
   logic [ZCW-1:0]   zc;
   logic [RCW-1:0]   rc;
   logic [RCW-1:0]   r_nxt;
   logic             player_ok;
   logic             zone_idx_ok;
   logic             region_idx_ok;
   logic             part_empty_err;
   logic             zone_hit;
   logic             region_hit;
   logic             zone_fits;
   logic             want;
   logic             out_load;
   logic [ID_W-1:0]  quadrant_id;

   assign zc = (32'(zone_count_ff) < ZONE_SLOTS) ? ZCW'(zone_count_ff) : ZCW'(ZONE_SLOTS);
   assign rc = (32'(region_count_ff) < REGION_SLOTS) ? RCW'(region_count_ff)
                                                     : RCW'(REGION_SLOTS);
   assign r_nxt          = r_ff + 1'b1;
   assign player_ok      = 32'(item_ff.player) < PLAYER_SLOTS;
   assign zone_idx_ok    = 32'(item_ff.entry_index) < ZONE_SLOTS;
   assign region_idx_ok  = 32'(item_ff.entry_index) < REGION_SLOTS;
   assign part_empty_err = (rc == '0) && (zc != '0);
   assign zone_hit   = box_holds(zm_rd_entry.box, item_ff.pos_x, item_ff.pos_y, item_ff.pos_z);
   assign region_hit = box_holds(rm_rd_entry.box, item_ff.pos_x, item_ff.pos_y, item_ff.pos_z);
   assign zone_fits  = fits_xy(zm_rd_entry.box, rm_rd_entry.box);
   assign want       = item_ff.is_spawned & item_ff.show_pref;
   assign quadrant_id = qbase_ff + ((item_ff.pos_y < 20'sd0) ? 10'd2 : 10'd0)
                                 + ((item_ff.pos_x > 20'sd0) ? 10'd1 : 10'd0);
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign item_entry = '{box: '{min_x: item_ff.pos_x, min_y: item_ff.pos_y,
                                min_z: item_ff.pos_z, max_x: item_ff.box_max_x,
                                max_y: item_ff.box_max_y, max_z: item_ff.box_max_z},
                         id: item_ff.entry_id};

   zlc_zone_mem #(.ZONE_SLOTS(ZONE_SLOTS)) u_zone_mem (
      .clock       (clock),
      .wr_en       (zm_wr_en),
      .wr_addr     (zm_wr_addr),
      .wr_entry    (item_entry),
      .rd_addr     (zm_rd_addr),
      .rd_entry_ff (zm_rd_entry)
   );

   zlc_region_mem #(.REGION_SLOTS(REGION_SLOTS), .ZONE_SLOTS(ZONE_SLOTS)) u_region_mem (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (rm_wr_en),
      .wr_addr      (rm_wr_addr),
      .wr_entry     (item_entry),
      .from_wr_en   (from_wr_en),
      .from_wr_addr (from_wr_addr),
      .from_wr_val  (from_wr_val),
      .to_wr_en     (to_wr_en),
      .to_wr_addr   (r_ff[RW-1:0]),
      .to_wr_val    (to_wr_val),
      .rd_addr      (rm_rd_addr),
      .rd_entry_ff  (rm_rd_entry),
      .rd_from      (rm_rd_from),
      .rd_to        (rm_rd_to)
   );

   zlc_player_mem #(.PLAYER_SLOTS(PLAYER_SLOTS)) u_player_mem (
      .clock      (clock),
      .reset      (reset),
      .addr       (PW'(item_ff.player)),
      .ctrl       (pl_ctrl),
      .wr_entry   (pl_wr_entry),
      .clr_region (inv_ff),
      .rd_entry   (pl_rd_entry),
      .rd_shown   (pl_rd_shown)
   );

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_count_ff   <= '0;
         region_count_ff <= '0;
         qbase_ff        <= '0;
         inv_ff          <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ZONE_COUNT:     zone_count_ff   <= csr_wr_data;
            CSR_REGION_COUNT:   region_count_ff <= csr_wr_data[4:0];
            CSR_QUADRANT_BASE:  qbase_ff        <= csr_wr_data;
            CSR_INVALID_REGION: inv_ff          <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd_type'(item_ff.command) == CMD_LOCATE && player_ok) begin
               state_in = ST_PLAYER;
            end else if (cmd_type'(item_ff.command) == CMD_PARTITION && !part_empty_err) begin
               state_in = ST_P_RD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_PLAYER: begin
            if (!item_ff.is_spawned) state_in = ST_OUT;
            else if (pl_rd_entry.ok) state_in = ST_CZ;
            else state_in = ST_R_RD;
         end
         ST_CZ:    state_in = zone_hit ? ST_OUT : ST_R_RD;
         ST_R_RD:  state_in = (r_ff < rc) ? ST_R_CHK : ST_FIN;
         ST_R_CHK: state_in = region_hit ? ST_Z_RD : ST_R_RD;
         ST_Z_RD:  state_in = (z_ff < hi_ff) ? ST_Z_CHK : ST_FIN;
         ST_Z_CHK: state_in = zone_hit ? ST_FIN : ST_Z_RD;
         ST_FIN:   state_in = ST_OUT;
         ST_P_RD:  state_in = (z_ff < zc) ? ST_P_CHK : ST_OUT;
         ST_P_CHK: begin
            if (!zone_fits && ({1'b0, r_nxt} >= {1'b0, rc})) state_in = ST_OUT;
            else state_in = ST_P_RD;
         end
         ST_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      item_in      = item_ff;
      r_in         = r_ff;
      z_in         = z_ff;
      hi_in        = hi_ff;
      ok_in        = ok_ff;
      zidx_in      = zidx_ff;
      zid_in       = zid_ff;
      reg_in       = reg_ff;
      act_in       = act_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      shown_in     = shown_ff;
      zm_wr_en     = 1'b0;
      zm_wr_addr   = ZW'(item_ff.entry_index);
      zm_rd_addr   = z_ff[ZW-1:0];
      rm_wr_en     = 1'b0;
      rm_wr_addr   = RW'(item_ff.entry_index);
      rm_rd_addr   = r_ff[RW-1:0];
      from_wr_en   = 1'b0;
      from_wr_addr = r_nxt[RW-1:0];
      from_wr_val  = z_ff;
      to_wr_en     = 1'b0;
      to_wr_val    = z_ff;
      pl_ctrl      = '0;
      pl_wr_entry  = '{ok: 1'b0, idx: '0, zid: '0, region: inv_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) item_in = req_data;
         end
         ST_EXEC: begin
            r_in    = '0;
            z_in    = '0;
            ok_in   = 1'b0;
            zidx_in = '0;
            zid_in  = '0;
            reg_in  = '0;
            act_in  = ACT_NONE;
            err_in  = 1'b0;
            case (cmd_type'(item_ff.command))
               CMD_WR_REGION: rm_wr_en = region_idx_ok;
               CMD_WR_ZONE:   zm_wr_en = zone_idx_ok;
               CMD_PARTITION: begin
                  pl_ctrl.clear_all = 1'b1;
                  if (part_empty_err) begin
                     err_in = 1'b1;
                  end else begin
                     // first run starts at zone 0
                     from_wr_en   = 1'b1;
                     from_wr_addr = '0;
                     from_wr_val  = '0;
                  end
               end
               CMD_RESET_PLAYER: begin
                  if (player_ok) begin
                     pl_ctrl.wr_en       = 1'b1;
                     pl_ctrl.shown_wr_en = 1'b1;
                     pl_ctrl.shown_val   = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         ST_PLAYER: begin
            prev_in  = pl_rd_entry;
            shown_in = pl_rd_shown;
            if (!item_ff.is_spawned) begin
               // drop cached zone, keep region, hide if shown
               pl_ctrl.wr_en      = 1'b1;
               pl_wr_entry.region = pl_rd_entry.region;
               reg_in             = pl_rd_entry.region;
               if (pl_rd_shown) begin
                  pl_ctrl.shown_wr_en = 1'b1;
                  act_in              = ACT_HIDE;
               end
            end else if (pl_rd_entry.ok) begin
               zm_rd_addr = pl_rd_entry.idx[ZW-1:0];
            end
         end
         ST_CZ: begin
            if (zone_hit) begin
               ok_in  = 1'b1;
               zid_in = prev_ff.zid;
               reg_in = prev_ff.region;
               if (!want) begin
                  if (shown_ff) begin
                     pl_ctrl.shown_wr_en = 1'b1;
                     act_in              = ACT_HIDE;
                  end
               end else if (!shown_ff) begin
                  pl_ctrl.shown_wr_en = 1'b1;
                  pl_ctrl.shown_val   = 1'b1;
                  act_in              = ACT_SHOW;
               end
            end
         end
         ST_R_RD: begin
            if (r_ff >= rc) reg_in = quadrant_id;
         end
         ST_R_CHK: begin
            if (region_hit) begin
               reg_in = rm_rd_entry.id;
               z_in   = rm_rd_from;
               hi_in  = rm_rd_to;
            end else begin
               r_in = r_nxt;
            end
         end
         ST_Z_CHK: begin
            if (zone_hit) begin
               ok_in   = 1'b1;
               zidx_in = CIDX_W'(z_ff);
               zid_in  = zm_rd_entry.id;
            end else begin
               z_in = z_ff + 1'b1;
            end
         end
         ST_FIN: begin
            pl_ctrl.wr_en = 1'b1;
            pl_wr_entry   = '{ok: ok_ff, idx: zidx_ff, zid: zid_ff, region: reg_ff};
            if (!want) begin
               if (shown_ff) begin
                  pl_ctrl.shown_wr_en = 1'b1;
                  act_in              = ACT_HIDE;
               end
            end else if (!shown_ff) begin
               pl_ctrl.shown_wr_en = 1'b1;
               pl_ctrl.shown_val   = 1'b1;
               act_in              = ACT_SHOW;
            end else if (prev_ff.region != reg_ff || prev_ff.ok != ok_ff ||
                         prev_ff.zid != zid_ff) begin
               act_in = ACT_UPDATE;
            end
         end
         ST_P_RD: begin
            if (z_ff >= zc) begin
               // close the last run
               to_wr_en  = 1'b1;
               to_wr_val = zc;
            end
         end
         ST_P_CHK: begin
            if (zone_fits) begin
               z_in = z_ff + 1'b1;
            end else begin
               to_wr_en = 1'b1;
               if ({1'b0, r_nxt} >= {1'b0, rc}) begin
                  err_in = 1'b1;
               end else begin
                  from_wr_en = 1'b1;
                  r_in       = r_nxt;
               end
            end
         end
         default: ;
      endcase
   end

   // output register
   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (out_load) begin
         rsp_data_in.action          = act_ff;
         rsp_data_in.zone_found      = ok_ff;
         rsp_data_in.zone_id         = ok_ff ? zid_ff : '0;
         rsp_data_in.region_id       = reg_ff;
         rsp_data_in.partition_error = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      r_ff        <= r_in;
      z_ff        <= z_in;
      hi_ff       <= hi_in;
      ok_ff       <= ok_in;
      zidx_ff     <= zidx_in;
      zid_ff      <= zid_in;
      reg_ff      <= reg_in;
      act_ff      <= act_in;
      err_ff      <= err_in;
      prev_ff     <= prev_in;
      shown_ff    <= shown_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
